FILE: src/assert_macros.svh
// Assertion helper macros for the ASCII hex frame receiver.
// Included by the modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, sampled on the rising clock edge and off during reset.
`define AHFR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("ahfr assertion failed");

// Same-cycle implication check.
`define AHFR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ahfr implication failed");

`endif

FILE: src/ahfr_pkg.sv
// Shared types, constants and hex helpers of the ASCII hex frame receiver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ahfr_pkg;

   localparam logic [7:0]  START_CHAR = 8'h3A;      // ':'
   localparam logic [7:0]  END_CHAR   = 8'h0D;      // carriage return
   localparam logic [8:0]  MIN_FRAME  = 9'd11;      // 9 + 2
   localparam logic [8:0]  COUNT_MAX  = 9'd511;
   localparam logic [3:0]  NIBBLE     = 4'hF;
   localparam logic [30:0] GAP_RESET  = 31'd29825;  // 1193 * 25

   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic [0:0]  REG_GAP_LIMIT = 1'b0;

   typedef enum logic [0:0] {
      KIND_DATA   = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_CHECKSUM = 2'd1,
      STATUS_SIZE     = 2'd2,
      STATUS_SHORT    = 2'd3
   } status_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_char;
      status_type status;
      logic [7:0] source_addr;
      logic [7:0] dest_addr;
      logic [7:0] msg_code;
      logic [7:0] data_length;
      logic [7:0] frame_channel;
   } result_type;

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] v;
      if (c inside {[8'h41:8'h7F]}) begin
         v = c - 8'h41 + 8'd10;
      end else begin
         v = c - 8'h30;
      end
      return v[3:0] & NIBBLE;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      if (n > 4'd9) begin
         return {4'h0, n} + 8'h41 - 8'd10;
      end
      return {4'h0, n} + 8'h30;
   endfunction

endpackage

`default_nettype wire

FILE: src/ascii_hex_frame_receiver_unit.sv
// Top level of the ASCII hex frame receiver.
// Depends on ahfr_pkg, ahfr_csr, ahfr_core and ahfr_out_buf.
//
// Usage:
//  - Request channel (req_valid / req_stall): one logged serial character per
//    transaction with its channel and tick time.
//  - Response channel (rsp_valid / rsp_stall): zero or one result per
//    character: a tentative data character (kind 0, two characters late) or
//    a frame end status with the decoded header (kind 1).
//  - csr_* port: APB-style access to gap_limit at byte address 0.
// Timing: a character is registered in the input register on acceptance,
//  processed from there once the output buffer has room, and its result
//  written into a two-entry output buffer that drives rsp_*.
// Throughput: one character per cycle while the output buffer is not full.
// Stall: while the receiver stalls, results collect in the output buffer;
//  once it holds two, the input register holds its character and req_stall
//  rises until an entry drains.
// Reset: synchronous; the tracker returns to hunting for ':' and gap_limit
//  returns to 29825 ticks.
`timescale 1ns / 1ps
`default_nettype none

module ascii_hex_frame_receiver_unit
   import ahfr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_rx_char,
   input  wire logic [7:0]            req_line_channel,
   input  wire logic [31:0]           req_tick_time,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_result_kind,
   output logic      [7:0]            rsp_data_char,
   output logic      [1:0]            rsp_status,
   output logic      [7:0]            rsp_source_addr,
   output logic      [7:0]            rsp_dest_addr,
   output logic      [7:0]            rsp_msg_code,
   output logic      [7:0]            rsp_data_length,
   output logic      [7:0]            rsp_frame_channel,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready
);

   logic [30:0] gap_limit;
   logic        buf_full;
   logic        push_valid;
   result_type  push_data;
   result_type  rsp_data;

   ahfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .gap_limit   (gap_limit)
   );

   ahfr_core u_core (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_char      (req_rx_char),
      .req_line_channel (req_line_channel),
      .req_tick_time    (req_tick_time),
      .gap_limit        (gap_limit),
      .buf_full         (buf_full),
      .push_valid       (push_valid),
      .push_data        (push_data)
   );

   ahfr_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .buf_full   (buf_full),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   assign rsp_result_kind   = rsp_data.kind;
   assign rsp_data_char     = rsp_data.data_char;
   assign rsp_status        = rsp_data.status;
   assign rsp_source_addr   = rsp_data.source_addr;
   assign rsp_dest_addr     = rsp_data.dest_addr;
   assign rsp_msg_code      = rsp_data.msg_code;
   assign rsp_data_length   = rsp_data.data_length;
   assign rsp_frame_channel = rsp_data.frame_channel;

endmodule

`default_nettype wire

FILE: src/ahfr_csr.sv
// APB-style register port holding gap_limit.
// Depends on ahfr_pkg for the address width and reset value.
`timescale 1ns / 1ps
`default_nettype none

module ahfr_csr
   import ahfr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready,
   output logic      [30:0]           gap_limit
);

   logic [30:0] gap_limit_ff;
   logic [30:0] gap_limit_in;
   logic        hit;

   // byte address 4*i -> register index in bit 2
   assign hit = (csr_paddr[2] == REG_GAP_LIMIT) && (csr_paddr[1:0] == 2'b00);

   always_comb begin
      gap_limit_in = gap_limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         gap_limit_in = csr_pwdata[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_limit_ff <= GAP_RESET;
      end else begin
         gap_limit_ff <= gap_limit_in;
      end
   end

   assign csr_prdata = hit ? {1'b0, gap_limit_ff} : 32'h0;
   assign csr_pready = 1'b1;
   assign gap_limit  = gap_limit_ff;

endmodule

`default_nettype wire

FILE: src/ahfr_core.sv
// Input register and frame tracker: one char per cycle unless stalled, <=1 result out.
// Depends on ahfr_pkg for constants, result struct and hex helpers.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ahfr_core
   import ahfr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_char,
   input  wire logic [7:0]  req_line_channel,
   input  wire logic [31:0] req_tick_time,
   input  wire logic [30:0] gap_limit,
   input  wire logic        buf_full,
   output logic             push_valid,
   output result_type       push_data
);

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_char_ff, in_chan_ff;
   logic [31:0] in_time_ff;

   // frame state
   logic        in_frame_ff, in_frame_in;
   logic [8:0]  count_ff, count_in;
   logic [7:0]  src_ff, src_in, dst_ff, dst_in, code_ff, code_in, len_ff, len_in;
   logic [7:0]  xor_ff, xor_in, chk0_ff, chk0_in, chk1_ff, chk1_in;
   logic [7:0]  prev_chan_ff;
   logic [31:0] prev_time_ff;

   logic        accept, fire;
   logic [31:0] diff;
   logic        brk, hunt, start;
   logic [2:0]  hdr_pos;
   logic [3:0]  nib;
   status_type  st;
   logic [8:0]  size_diff;

   assign fire      = in_valid_ff && !buf_full;
   assign req_stall = in_valid_ff && buf_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   assign diff = in_time_ff - prev_time_ff;
   // negative tick differences never break a frame
   assign brk  = in_frame_ff && ((in_chan_ff != prev_chan_ff) ||
                                 (!diff[31] && (diff[30:0] > gap_limit)));
   assign hunt  = !in_frame_ff || brk;
   assign start = hunt && (in_char_ff == START_CHAR);

   assign size_diff = count_ff - MIN_FRAME;
   assign hdr_pos   = count_ff[2:0] - 3'd1;
   assign nib       = hex_nibble(in_char_ff);

   always_comb begin
      if (count_ff < MIN_FRAME) begin
         st = STATUS_SHORT;
      end else if (size_diff != {1'b0, len_ff}) begin
         st = STATUS_SIZE;
      end else if ((chk0_ff == hex_digit(xor_ff[7:4])) &&
                   (chk1_ff == hex_digit(xor_ff[3:0]))) begin
         st = STATUS_OK;
      end else begin
         st = STATUS_CHECKSUM;
      end
   end

   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      code_in     = code_ff;
      len_in      = len_ff;
      xor_in      = xor_ff;
      chk0_in     = chk0_ff;
      chk1_in     = chk1_ff;
      push_valid  = 1'b0;
      push_data   = '0;

      if (in_frame_ff) begin
         if (brk || (in_char_ff == END_CHAR)) begin
            push_valid              = 1'b1;
            push_data.kind          = KIND_STATUS;
            push_data.status        = st;
            push_data.source_addr   = src_ff;
            push_data.dest_addr     = dst_ff;
            push_data.msg_code      = code_ff;
            push_data.data_length   = len_ff;
            push_data.frame_channel = prev_chan_ff;
            in_frame_in             = 1'b0;
         end else begin
            if ((count_ff >= 9'd1) && (count_ff <= 9'd8)) begin
               // header digit: odd position is the high nibble
               case (hdr_pos[2:1])
                  2'd0: begin
                     src_in = count_ff[0] ? {nib, src_ff[3:0]} : {src_ff[7:4], nib};
                  end
                  2'd1: begin
                     dst_in = count_ff[0] ? {nib, dst_ff[3:0]} : {dst_ff[7:4], nib};
                  end
                  2'd2: begin
                     code_in = count_ff[0] ? {nib, code_ff[3:0]} : {code_ff[7:4], nib};
                  end
                  default: begin
                     len_in = count_ff[0] ? {nib, len_ff[3:0]} : {len_ff[7:4], nib};
                  end
               endcase
               xor_in = xor_ff ^ in_char_ff;
            end else if (count_ff >= 9'd9) begin
               // data lags two characters so the checksum pair is never passed on
               if (count_ff >= MIN_FRAME) begin
                  xor_in              = xor_ff ^ chk0_ff;
                  push_valid          = 1'b1;
                  push_data.kind      = KIND_DATA;
                  push_data.data_char = chk0_ff;
               end
               chk0_in = chk1_ff;
               chk1_in = in_char_ff;
            end
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + 9'd1;
            end
         end
      end

      if (start) begin
         in_frame_in = 1'b1;
         count_in    = 9'd1;
         src_in      = '0;
         dst_in      = '0;
         code_in     = '0;
         len_in      = '0;
         xor_in      = '0;
         chk0_in     = '0;
         chk1_in     = '0;
      end

      if (!fire) begin
         push_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         in_frame_ff  <= 1'b0;
         count_ff     <= '0;
         src_ff       <= '0;
         dst_ff       <= '0;
         code_ff      <= '0;
         len_ff       <= '0;
         xor_ff       <= '0;
         chk0_ff      <= '0;
         chk1_ff      <= '0;
         prev_chan_ff <= '0;
         prev_time_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (fire) begin
            in_frame_ff  <= in_frame_in;
            count_ff     <= count_in;
            src_ff       <= src_in;
            dst_ff       <= dst_in;
            code_ff      <= code_in;
            len_ff       <= len_in;
            xor_ff       <= xor_in;
            chk0_ff      <= chk0_in;
            chk1_ff      <= chk1_in;
            prev_chan_ff <= in_chan_ff;
            prev_time_ff <= in_time_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff <= req_rx_char;
         in_chan_ff <= req_line_channel;
         in_time_ff <= req_tick_time;
      end
   end

   `AHFR_ASSERT_IMP(a_hunt_silent, clock, reset, fire && !in_frame_ff, !push_valid)
   `AHFR_ASSERT_IMP(a_data_late, clock, reset,
      push_valid && (push_data.kind == KIND_DATA), count_ff >= MIN_FRAME)
   `AHFR_ASSERT_IMP(a_frame_count, clock, reset, in_frame_ff, count_ff != 9'd0)

endmodule

`default_nettype wire

FILE: src/ahfr_out_buf.sv
// Two-entry result buffer between the frame tracker and the result channel.
// Depends on ahfr_pkg for the result struct.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ahfr_out_buf
   import ahfr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push_valid,
   input  wire result_type push_data,
   output logic            buf_full,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output result_type      rsp_data
);

   result_type mem [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic       pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign buf_full  = (count_ff == 2'd2);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push_valid} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   `AHFR_ASSERT(a_no_overflow, clock, reset, !(push_valid && buf_full))
   `AHFR_ASSERT(a_count_range, clock, reset, count_ff != 2'd3)

endmodule

`default_nettype wire

FILE: tb/tb_ascii_hex_frame_receiver_unit.sv
// Self-checking testbench for ascii_hex_frame_receiver_unit: frames, noise and gap settings.
// Expected results come from a scoreboard class that tracks frame state per character.
// Depends on ahfr_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_ascii_hex_frame_receiver_unit
   import ahfr_pkg::*;
;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam logic [CSR_ADDR_W-1:0] GAP_LIMIT_ADDR = CSR_ADDR_W'(4 * REG_GAP_LIMIT);
   localparam logic [30:0] GAP_MAX = 31'h7FFF_FFFF;

   class frame_checker;
      logic [30:0] gap_limit;
      bit          framing;
      logic [8:0]  count;
      logic [7:0]  hdr [4];
      logic [7:0]  xsum;
      logic [7:0]  tail [2];
      logic [7:0]  last_chan;
      logic [31:0] last_tick;
      result_type  pending [$];
      int          errors;

      function new();
         gap_limit = GAP_RESET;
         framing   = 1'b0;
         count     = '0;
         hdr       = '{default: 8'h00};
         xsum      = '0;
         tail      = '{default: 8'h00};
         last_chan = '0;
         last_tick = '0;
         errors    = 0;
      endfunction

      function logic [7:0] upper_hex(input logic [3:0] n);
         return (n > 4'd9) ? 8'h37 + 8'(n) : 8'h30 + 8'(n);
      endfunction

      function logic [3:0] nibble_of(input logic [7:0] c);
         return (c >= 8'h41 && c <= 8'h7F) ? 4'(c - 8'd55) : c[3:0];
      endfunction

      function void close_frame();
         result_type r;
         r = '0;
         r.kind = KIND_STATUS;
         if (count < MIN_FRAME)
            r.status = STATUS_SHORT;
         else if (count - MIN_FRAME != {1'b0, hdr[3]})
            r.status = STATUS_SIZE;
         else if (tail[0] == upper_hex(xsum[7:4]) && tail[1] == upper_hex(xsum[3:0]))
            r.status = STATUS_OK;
         else
            r.status = STATUS_CHECKSUM;
         r.source_addr   = hdr[0];
         r.dest_addr     = hdr[1];
         r.msg_code      = hdr[2];
         r.data_length   = hdr[3];
         r.frame_channel = last_chan;
         pending.push_back(r);
         framing = 1'b0;
      endfunction

      // Data goes out two characters late so the checksum pair never does.
      function void take_char(input logic [7:0] c);
         result_type r;
         logic [1:0] slot;
         if (count >= 1 && count <= 8) begin
            slot = 2'((count - 1) >> 1);
            if (count[0])
               hdr[slot][7:4] = nibble_of(c);
            else
               hdr[slot][3:0] = nibble_of(c);
            xsum ^= c;
         end else if (count >= 9) begin
            if (count >= MIN_FRAME) begin
               xsum ^= tail[0];
               r = '0;
               r.kind = KIND_DATA;
               r.data_char = tail[0];
               pending.push_back(r);
            end
            tail[0] = tail[1];
            tail[1] = c;
         end
         if (count != COUNT_MAX)
            count++;
      endfunction

      function void note_char(input logic [7:0] c, input logic [7:0] ch, input logic [31:0] t);
         logic [31:0] diff;
         bit hunt;
         hunt = !framing;
         if (framing) begin
            diff = t - last_tick;
            if (ch != last_chan || (!diff[31] && diff > {1'b0, gap_limit})) begin
               close_frame();
               hunt = 1'b1;
            end else if (c == END_CHAR) begin
               close_frame();
            end else begin
               take_char(c);
            end
         end
         if (hunt && c == START_CHAR) begin
            framing = 1'b1;
            count   = 9'd1;
            hdr     = '{default: 8'h00};
            xsum    = '0;
            tail    = '{default: 8'h00};
         end
         last_chan = ch;
         last_tick = t;
      endfunction

      function void compare_field(input string name, input logic [7:0] want,
                                  input logic [7:0] got);
         if (got !== want) begin
            $error("%s expected 0x%0h actual 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(input result_type got);
         result_type want;
         if (pending.size() == 0) begin
            $error("unexpected result transaction, kind %0d", got.kind);
            errors++;
            return;
         end
         want = pending.pop_front();
         compare_field("result_kind", 8'(want.kind), 8'(got.kind));
         compare_field("data_char", want.data_char, got.data_char);
         compare_field("status", 8'(want.status), 8'(got.status));
         compare_field("source_addr", want.source_addr, got.source_addr);
         compare_field("dest_addr", want.dest_addr, got.dest_addr);
         compare_field("msg_code", want.msg_code, got.msg_code);
         compare_field("data_length", want.data_length, got.data_length);
         compare_field("frame_channel", want.frame_channel, got.frame_channel);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_rx_char = '0;
   logic [7:0]            req_line_channel = '0;
   logic [31:0]           req_tick_time = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_result_kind;
   logic [7:0]            rsp_data_char;
   logic [1:0]            rsp_status;
   logic [7:0]            rsp_source_addr;
   logic [7:0]            rsp_dest_addr;
   logic [7:0]            rsp_msg_code;
   logic [7:0]            rsp_data_length;
   logic [7:0]            rsp_frame_channel;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   frame_checker sb = new();
   bit           calm = 1'b0;
   bit           force_break = 1'b0;
   int           n_sent = 0;
   int           idle_cycles = 0;
   logic [7:0]   cur_chan = '0;
   logic [31:0]  tick_now = '0;

   ascii_hex_frame_receiver_unit u_top (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin : rsp_side
      result_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.kind          = kind_type'(rsp_result_kind);
         seen.data_char     = rsp_data_char;
         seen.status        = status_type'(rsp_status);
         seen.source_addr   = rsp_source_addr;
         seen.dest_addr     = rsp_dest_addr;
         seen.msg_code      = rsp_msg_code;
         seen.data_length   = rsp_data_length;
         seen.frame_channel = rsp_frame_channel;
         sb.check_result(seen);
      end
      rsp_stall <= !calm && ($urandom_range(0, 99) < 25);
   end

   always @(posedge clock) begin
      if (reset || csr_psel || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [30:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= {1'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.gap_limit = value;
   endtask

   task automatic drive_char(input logic [7:0] c, input logic [7:0] ch, input logic [31:0] t);
      if (!calm) begin
         while ($urandom_range(0, 99) < 25) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid        <= 1'b1;
      req_rx_char      <= c;
      req_line_channel <= ch;
      req_tick_time    <= t;
      do @(posedge clock); while (req_stall);
      if (sb.framing || c == START_CHAR)
         n_sent++;
      sb.note_char(c, ch, t);
   endtask

   // Mostly gaps inside the limit; sometimes exactly at it, or backward in time; above it when over is set.
   function automatic logic [31:0] next_tick(input bit over);
      longint unsigned lim;
      longint unsigned room;
      int unsigned r;
      lim = sb.gap_limit;
      if (over) begin
         room = 64'h7FFF_FFFF - lim - 1;
         if (room > 500)
            room = 500;
         return tick_now + 32'(lim + 1 + $urandom_range(0, 32'(room)));
      end
      r = $urandom_range(0, 99);
      if (r < 5)
         return tick_now + 32'(lim);
      if (r < 9)
         return tick_now + (32'h8000_0000 | $urandom());
      return tick_now + $urandom_range(0, lim < 40 ? 32'(lim) : 40);
   endfunction

   task automatic put_char(input logic [7:0] c, input bit brk);
      if (brk || force_break) begin
         force_break = 1'b0;
         if (sb.gap_limit != GAP_MAX && $urandom_range(0, 1) == 1) begin
            tick_now = next_tick(1'b1);
         end else begin
            cur_chan = cur_chan + 8'($urandom_range(1, 255));
            tick_now = next_tick(1'b0);
         end
      end else begin
         tick_now = next_tick(1'b0);
      end
      drive_char(c, cur_chan, tick_now);
   endtask

   function automatic logic [7:0] any_but_cr();
      logic [7:0] c;
      c = 8'($urandom);
      return (c == END_CHAR) ? 8'h0E : c;
   endfunction

   // Well-formed frame with random content, or one of the broken shapes.
   task automatic send_frame(input int len);
      logic [7:0] body [$];
      logic [7:0] hdr [4];
      logic [7:0] acc;
      logic [7:0] c;
      logic [3:0] nib;
      int unsigned shape;
      bit lower;
      shape  = $urandom_range(0, 99);
      lower  = ($urandom_range(0, 3) == 0);
      hdr[0] = 8'($urandom);
      hdr[1] = 8'($urandom);
      hdr[2] = 8'($urandom);
      hdr[3] = (shape < 10) ? 8'(len + $urandom_range(1, 3)) : 8'(len);
      body.push_back(START_CHAR);
      for (int i = 0; i < 8; i++) begin
         nib = i[0] ? hdr[i / 2][3:0] : hdr[i / 2][7:4];
         c = sb.upper_hex(nib);
         if (lower && nib > 4'd9 && $urandom_range(0, 1) == 1)
            c = c | 8'h20;
         if (i < 6 && $urandom_range(0, 19) == 0)
            c = any_but_cr();
         body.push_back(c);
      end
      for (int i = 0; i < len; i++)
         body.push_back(any_but_cr());
      acc = '0;
      for (int i = 1; i < body.size(); i++)
         acc ^= body[i];
      body.push_back(sb.upper_hex(acc[7:4]));
      body.push_back(sb.upper_hex(acc[3:0]));
      if (shape >= 10 && shape < 20)
         body[body.size() - 1 - $urandom_range(0, 1)] ^= 8'($urandom_range(1, 7));
      if (shape >= 20 && shape < 26) begin
         repeat ($urandom_range(1, body.size() - 1))
            void'(body.pop_back());
      end
      if (!(shape >= 26 && shape < 34))
         body.push_back(END_CHAR);
      foreach (body[i])
         put_char(body[i], i == 0 && sb.framing);
      // no carriage return: the next character breaks the frame
      if (shape >= 26 && shape < 34)
         force_break = 1'b1;
   endtask

   task automatic send_noise();
      int unsigned r;
      logic [7:0] c;
      r = $urandom_range(0, 99);
      if (r < 8)
         cur_chan = 8'($urandom);
      c = (r < 15) ? END_CHAR : (r < 22) ? START_CHAR : 8'($urandom);
      put_char(c, r >= 95);
   endtask

   task automatic random_items(input int n);
      int target;
      int unsigned r;
      target = n_sent + n;
      while (n_sent < target) begin
         r = $urandom_range(0, 99);
         if (r < 75) begin
            r = $urandom_range(0, 99);
            send_frame(r < 85 ? $urandom_range(0, 12) :
                       r < 97 ? $urandom_range(13, 60) : $urandom_range(100, 255));
         end else begin
            send_noise();
         end
      end
   endtask

   // Sender holds off until every expected transaction is back and the pipe is empty.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic directed_items();
      logic [7:0] frame [$];
      logic [7:0] acc;
      drive_char(END_CHAR, 8'd0, 32'd0);
      drive_char(8'h00, 8'hFF, 32'hFFFF_FFFF);
      drive_char(8'hFF, 8'd0, 32'h8000_0000);
      // gap exactly at the limit continues, one above breaks
      drive_char(START_CHAR, 8'd7, 32'd100);
      drive_char("5", 8'd7, 32'd100 + 32'd29825);
      drive_char("6", 8'd7, 32'd100 + 32'd29825 + 32'd29826);
      // channel change ends a frame; the breaking ':' opens the next one
      drive_char(START_CHAR, 8'd7, 32'd60000);
      drive_char(START_CHAR, 8'd8, 32'd60000);
      drive_char("9", 8'd8, 32'd59000);
      drive_char(END_CHAR, 8'd8, 32'd59000);
      // complete frame, lowercase header, ':' as data, ticks wrap through zero
      frame = '{START_CHAR, "a", "1", "0", "2", "0", "3", "0", "1", START_CHAR};
      acc = '0;
      for (int i = 1; i < frame.size(); i++)
         acc ^= frame[i];
      frame.push_back(sb.upper_hex(acc[7:4]));
      frame.push_back(sb.upper_hex(acc[3:0]));
      frame.push_back(END_CHAR);
      foreach (frame[i])
         drive_char(frame[i], 8'd0, 32'hFFFF_FFF8 + 32'(3 * i));
      tick_now = 32'hFFFF_FFF8 + 32'(3 * frame.size());
      cur_chan = 8'd0;
   endtask

   initial begin
      logic [30:0] gap_plan [4];
      int plan_items [4];
      gap_plan   = '{31'd0, GAP_MAX, 31'd40, 31'd5000};
      plan_items = '{15, 5, 15, 15};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_items();
      random_items(30);
      drain();
      for (int p = 0; p < 4; p++) begin
         csr_write(GAP_LIMIT_ADDR, gap_plan[p]);
         calm = (p == 1);
         tick_now = $urandom();
         cur_chan = 8'($urandom);
         if (gap_plan[p] == GAP_MAX)
            send_frame(520);  // runs the character count into saturation
         random_items(plan_items[p]);
         drain();
      end
      repeat (10) @(posedge clock);
      if (sb.pending.size() != 0) begin
         $error("%0d expected result transactions never arrived", sb.pending.size());
         sb.errors++;
      end
      if (sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
